// File: hdl/quaternion_slerp_top_assert.svh
// Assertion macros for the checker of the slerp block.
// Both take the clock and reset by the names i_clk and i_rst_n.
`ifndef QUATERNION_SLERP_TOP_ASSERT_SVH
`define QUATERNION_SLERP_TOP_ASSERT_SVH

// Same-cycle implication.
`define QSLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define QSLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/qslp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qslp_pkg;

    localparam int FRAC_BITS       = 14;
    localparam int TRIG_ITERATIONS = 16;

    // Request and result payloads.
    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] a_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] b_w;
        logic        [15:0] blend;
    } t_req;

    typedef struct packed {
        logic signed [15:0] r_x;
        logic signed [15:0] r_y;
        logic signed [15:0] r_z;
        logic signed [15:0] r_w;
        logic               degenerate;
    } t_rsp;

    typedef logic [3:0][15:0] t_quat;

    // Fixed-point constants, 30 fraction bits.
    localparam int Q30_FB = 30;
    localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
    localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [15:0] Q_MAX       = 16'sh7FFF;
    localparam logic signed [15:0] Q_MIN       = -16'sh8000;
    localparam logic        [15:0] T_ONE       = 16'h8000;

    // Dot product and cosine.
    localparam int DOT_W = 34;
    localparam int SCALE = 2 * FRAC_BITS - Q30_FB;
    localparam int SH_L  = (SCALE < 0) ? -SCALE : 0;
    localparam int SH_R  = (SCALE > 0) ? SCALE : 0;
    localparam int CW    = DOT_W + SH_L;
    localparam int C_W   = 32;

    // Integer square root.
    localparam int RAD_W      = 61;
    localparam int RT_W       = 62;
    localparam int SQRT_STEPS = 31;

    // Angle and sine rotators.
    localparam int XW    = 34;
    localparam int ZW    = 35;
    localparam int W_W   = 33;
    localparam int TH_W  = 34;
    localparam int SX_W  = 33;
    localparam int ZR_W  = 36 - TRIG_ITERATIONS;
    localparam int PW    = SX_W + ZR_W;
    localparam int S_W   = 34;

    // Ratio divider.
    localparam int DIV_QB  = 41;
    localparam int DIV_HI  = DIV_QB - Q30_FB;
    localparam int DIV_RW  = S_W + 1;
    localparam int K_W     = DIV_QB + 1;
    localparam int DIV_LAT = DIV_QB + 2;

    // Blend.
    localparam int BP_W = 16 + K_W;
    localparam int BS_W = BP_W + 1;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
        32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

    function automatic t_quat a_vec(input t_req q);
        return {q.a_w, q.a_z, q.a_y, q.a_x};
    endfunction

    function automatic t_quat b_vec(input t_req q);
        return {q.b_w, q.b_z, q.b_y, q.b_x};
    endfunction

endpackage

`default_nettype wire

// File: hdl/qslp_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: quot = trunc(num * 2^30 / den), clamped to +/-2^40.
module qslp_div (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [qslp_pkg::S_W-1:0]      i_num,
    input  logic signed [qslp_pkg::S_W-1:0]      i_den,
    output logic signed [qslp_pkg::K_W-1:0]      o_quot
);

    localparam int QB = qslp_pkg::DIV_QB;
    localparam int MW = qslp_pkg::S_W;
    localparam int RW = qslp_pkg::DIV_RW;
    localparam int KW = qslp_pkg::K_W;
    localparam int FB = qslp_pkg::Q30_FB;

    logic [MW-1:0] mag;
    logic [MW-1:0] den_u;

    logic [RW-1:0] r_rem [0:QB];
    logic [QB-1:0] r_q   [0:QB];
    logic [MW-1:0] r_den [0:QB];
    logic [MW-1:0] r_mag [0:QB];
    logic          r_neg [0:QB];
    logic          r_ovf [0:QB];
    logic signed [KW-1:0] r_quot;

    logic          big;
    logic [KW-1:0] kmag;

    assign mag   = i_num[MW-1] ? MW'(-i_num) : MW'(i_num);
    assign den_u = MW'(i_den);

    // Take the high part of the numerator and flag a quotient beyond the limit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(mag >> qslp_pkg::DIV_HI);
            r_q[0]   <= '0;
            r_den[0] <= den_u;
            r_mag[0] <= mag;
            r_neg[0] <= i_num[MW-1];
            r_ovf[0] <= (mag >> qslp_pkg::DIV_HI) >= den_u;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        localparam int B = QB - j;
        logic          fb;
        logic [RW-1:0] sh;
        logic          ge;

        if (B >= FB) begin : g_num
            assign fb = r_mag[j-1][B-FB];
        end else begin : g_zero
            assign fb = 1'b0;
        end

        assign sh = {r_rem[j-1][RW-2:0], fb};
        assign ge = sh >= RW'(r_den[j-1]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? sh - RW'(r_den[j-1]) : sh;
                r_q[j]   <= r_q[j-1] | (ge ? (QB'(1) << B) : '0);
                r_den[j] <= r_den[j-1];
                r_mag[j] <= r_mag[j-1];
                r_neg[j] <= r_neg[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    assign big  = r_ovf[QB] || (r_q[QB] > (QB'(1) << (QB - 1)));
    assign kmag = big ? (KW'(1) << (QB - 1)) : KW'(r_q[QB]);

    // Restore the sign, truncating toward zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= r_neg[QB] ? -$signed(kmag) : $signed(kmag);
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

// File: hdl/quaternion_slerp_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Quaternion slerp, fixed point. One request carries quaternions A and B
// (signed Q2.14) and a blend t (unsigned Q1.15, values above 1.0 are taken
// as 1.0); the result is slerp(A, B, t) rounded half up and saturated to
// Q2.14, or A itself with degenerate set when the sine of the angle between
// A and B is zero or negative. The block takes one request in every clock
// cycle while o_in_ready is high and returns results in request order. The
// pipeline is built from the 31-step square root, the two 16-step CORDIC
// chains and the 41-bit ratio dividers, each one step per register stage.
// The stream pipeline stalls as a whole only when the result register and
// its skid register are both full, so o_in_ready depends on registered state
// alone. Reset is synchronous and active low; it empties the pipeline.
module quaternion_slerp_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  qslp_pkg::t_req   i_req,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output qslp_pkg::t_rsp   o_rsp
);

    localparam int N     = qslp_pkg::TRIG_ITERATIONS;
    localparam int SQ0   = 4;                          // first square-root step
    localparam int A0    = SQ0 + qslp_pkg::SQRT_STEPS; // angle rotator set-up
    localparam int AE    = A0 + N;                     // last angle step
    localparam int WS    = AE + 1;                     // angle clamp
    localparam int MS    = WS + 1;                     // partial angles
    localparam int FS    = MS + 1;                     // fold and sine set-up
    localparam int SE    = FS + N;                     // last sine step
    localparam int CP    = SE + 1;                     // residual correction product
    localparam int SA    = CP + 1;                     // corrected sines
    localparam int D0    = SA + 1;                     // divider entry
    localparam int DL    = D0 + qslp_pkg::DIV_LAT - 1; // divider result
    localparam int BS    = DL + 1;                     // blend products
    localparam int ES    = BS + 1;                     // blend sum and saturate
    localparam int DEPTH = ES + 1;

    localparam int C_W  = qslp_pkg::C_W;
    localparam int XW   = qslp_pkg::XW;
    localparam int ZW   = qslp_pkg::ZW;
    localparam int W_W  = qslp_pkg::W_W;
    localparam int TH_W = qslp_pkg::TH_W;
    localparam int SX_W = qslp_pkg::SX_W;
    localparam int PW   = qslp_pkg::PW;
    localparam int S_W  = qslp_pkg::S_W;
    localparam int RT_W = qslp_pkg::RT_W;
    localparam int BP_W = qslp_pkg::BP_W;
    localparam int BS_W = qslp_pkg::BS_W;
    localparam int MP_W = W_W + 16;

    // ------------------------------------------------------------------
    // Flow control: the whole stream advances together while the skid
    // register is empty.
    // ------------------------------------------------------------------
    logic en;
    logic r_skid_vld;
    logic r_out_vld;
    qslp_pkg::t_rsp r_out;
    qslp_pkg::t_rsp r_skid;

    assign en         = !r_skid_vld;
    assign o_in_ready = en;

    // Valid bits, request context and the degenerate flag travel with
    // every stage.
    logic           r_vld [DEPTH];
    qslp_pkg::t_req r_ctx [DEPTH];
    logic           r_flg [DEPTH];
    logic           n_flg [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx[0] <= i_req;
            for (int k = 1; k < DEPTH; k++) begin
                r_ctx[k] <= r_ctx[k-1];
            end
            for (int k = 0; k < DEPTH; k++) begin
                r_flg[k] <= n_flg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Dot product, scale to 30 fraction bits and clamp to [-1, 1].
    // ------------------------------------------------------------------
    logic signed [31:0]                  r_prod [4];
    logic signed [qslp_pkg::DOT_W-1:0]   dot;
    logic signed [qslp_pkg::CW-1:0]      cwide;
    logic signed [C_W-1:0]               n_cos;
    logic signed [C_W-1:0]               r_cos [1:A0-1];
    logic [qslp_pkg::RAD_W-1:0]          r_csq;
    logic [qslp_pkg::RAD_W-1:0]          r_rad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod[0] <= i_req.a_x * i_req.b_x;
            r_prod[1] <= i_req.a_y * i_req.b_y;
            r_prod[2] <= i_req.a_z * i_req.b_z;
            r_prod[3] <= i_req.a_w * i_req.b_w;
        end
    end

    always_comb begin
        dot = qslp_pkg::DOT_W'(r_prod[0]) + qslp_pkg::DOT_W'(r_prod[1])
            + qslp_pkg::DOT_W'(r_prod[2]) + qslp_pkg::DOT_W'(r_prod[3]);
        // Shift right floors; shift left is exact. Only one of them is non-zero.
        cwide = (qslp_pkg::CW'(dot) <<< qslp_pkg::SH_L) >>> qslp_pkg::SH_R;
        if (cwide > qslp_pkg::CW'(qslp_pkg::ONE_Q30)) begin
            n_cos = C_W'(qslp_pkg::ONE_Q30);
        end else if (cwide < -qslp_pkg::CW'(qslp_pkg::ONE_Q30)) begin
            n_cos = -C_W'(qslp_pkg::ONE_Q30);
        end else begin
            n_cos = C_W'(cwide);
        end
    end

    // 1 - c*c, the radicand of the sine magnitude.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cos[1] <= n_cos;
            for (int k = 2; k < A0; k++) begin
                r_cos[k] <= r_cos[k-1];
            end
            r_csq <= qslp_pkg::RAD_W'(r_cos[1] * r_cos[1]);
            r_rad <= (qslp_pkg::RAD_W'(1) << (2 * qslp_pkg::Q30_FB)) - r_csq;
        end
    end

    // ------------------------------------------------------------------
    // Integer square root, one result bit per stage.
    // ------------------------------------------------------------------
    logic [RT_W-1:0] r_sv  [SQ0:A0-1];
    logic [RT_W-1:0] r_srt [SQ0:A0-1];

    for (genvar k = SQ0; k < A0; k++) begin : g_sqrt
        localparam int BP = 2 * (A0 - 1 - k);
        logic [RT_W-1:0] v_in;
        logic [RT_W-1:0] rt_in;
        logic [RT_W-1:0] trial;

        if (k == SQ0) begin : g_first
            assign v_in  = RT_W'(r_rad);
            assign rt_in = '0;
        end else begin : g_next
            assign v_in  = r_sv[k-1];
            assign rt_in = r_srt[k-1];
        end

        assign trial = rt_in + (RT_W'(1) << BP);

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (v_in >= trial) begin
                    r_sv[k]  <= v_in - trial;
                    r_srt[k] <= (rt_in >> 1) + (RT_W'(1) << BP);
                end else begin
                    r_sv[k]  <= v_in;
                    r_srt[k] <= rt_in >> 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle: atan2(sin, cos) by CORDIC vectoring.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] r_ax [A0:AE];
    logic signed [XW-1:0] r_ay [A0:AE];
    logic signed [ZW-1:0] r_az [A0:AE];
    logic signed [XW-1:0] ax0;
    logic signed [XW-1:0] ay0;

    assign ax0 = XW'(r_cos[A0-1]);
    assign ay0 = XW'(r_srt[A0-1]);

    // Rotate a negative cosine into the right half-plane first.
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (ax0 < 0) begin
                r_ax[A0] <= ay0;
                r_ay[A0] <= -ax0;
                r_az[A0] <= ZW'(qslp_pkg::HALF_PI_Q30);
            end else begin
                r_ax[A0] <= ax0;
                r_ay[A0] <= ay0;
                r_az[A0] <= '0;
            end
        end
    end

    for (genvar k = A0 + 1; k <= AE; k++) begin : g_vec
        localparam int S = k - A0 - 1;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_ay[k-1] > 0) begin
                    r_ax[k] <= r_ax[k-1] + (r_ay[k-1] >>> S);
                    r_ay[k] <= r_ay[k-1] - (r_ax[k-1] >>> S);
                    r_az[k] <= r_az[k-1] + ZW'(qslp_pkg::ATAN_Q30[S]);
                end else begin
                    r_ax[k] <= r_ax[k-1] - (r_ay[k-1] >>> S);
                    r_ay[k] <= r_ay[k-1] + (r_ax[k-1] >>> S);
                    r_az[k] <= r_az[k-1] - ZW'(qslp_pkg::ATAN_Q30[S]);
                end
            end
        end
    end

    // Clamp the angle to [0, pi] and the blend to [0, 1].
    logic [W_W-1:0] r_w;
    logic [15:0]    r_t;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_az[AE] < 0) begin
                r_w <= '0;
            end else if (r_az[AE] > ZW'(qslp_pkg::PI_Q30)) begin
                r_w <= W_W'(qslp_pkg::PI_Q30);
            end else begin
                r_w <= W_W'(r_az[AE]);
            end
            r_t <= (r_ctx[AE].blend > qslp_pkg::T_ONE) ? qslp_pkg::T_ONE : r_ctx[AE].blend;
        end
    end

    // Partial angles; lane 0 is w, lane 1 is w*t, lane 2 is w*(1-t).
    logic [W_W-1:0]  r_th [3];
    logic [MP_W-1:0] mp_t;
    logic [MP_W-1:0] mp_u;

    assign mp_t = MP_W'(r_w) * MP_W'(r_t);
    assign mp_u = MP_W'(r_w) * MP_W'(qslp_pkg::T_ONE - r_t);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_th[0] <= r_w;
            r_th[1] <= mp_t[W_W+14:15];
            r_th[2] <= mp_u[W_W+14:15];
        end
    end

    // ------------------------------------------------------------------
    // Three sines by CORDIC rotation, lanes side by side.
    // ------------------------------------------------------------------
    logic signed [SX_W-1:0] r_sx [FS:SE][3];
    logic signed [SX_W-1:0] r_sy [FS:SE][3];
    logic signed [TH_W-1:0] r_sz [FS:SE][3];

    // Fold angles above pi/2 onto the first quadrant.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_sx[FS][l] <= SX_W'(qslp_pkg::ONE_Q30);
                r_sy[FS][l] <= '0;
                if (TH_W'(r_th[l]) > TH_W'(qslp_pkg::HALF_PI_Q30)) begin
                    r_sz[FS][l] <= TH_W'(qslp_pkg::PI_Q30) - TH_W'(r_th[l]);
                end else begin
                    r_sz[FS][l] <= TH_W'(r_th[l]);
                end
            end
        end
    end

    for (genvar k = FS + 1; k <= SE; k++) begin : g_rot
        localparam int S = k - FS - 1;
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int l = 0; l < 3; l++) begin
                    if (r_sz[k-1][l] >= 0) begin
                        r_sx[k][l] <= r_sx[k-1][l] - (r_sy[k-1][l] >>> S);
                        r_sy[k][l] <= r_sy[k-1][l] + (r_sx[k-1][l] >>> S);
                        r_sz[k][l] <= r_sz[k-1][l] - TH_W'(qslp_pkg::ATAN_Q30[S]);
                    end else begin
                        r_sx[k][l] <= r_sx[k-1][l] + (r_sy[k-1][l] >>> S);
                        r_sy[k][l] <= r_sy[k-1][l] - (r_sx[k-1][l] >>> S);
                        r_sz[k][l] <= r_sz[k-1][l] + TH_W'(qslp_pkg::ATAN_Q30[S]);
                    end
                end
            end
        end
    end

    // First-order correction by x times the residual angle; the residual is
    // small after the last step, so a narrow slice of it is exact.
    logic signed [SX_W-1:0] r_cy [3];
    logic signed [PW-1:0]   r_cp [3];
    logic signed [S_W-1:0]  r_s  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_cy[l] <= r_sy[SE][l];
                r_cp[l] <= PW'(r_sx[SE][l]) * PW'(qslp_pkg::ZR_W'(r_sz[SE][l]));
                r_s[l]  <= S_W'(r_cy[l]) + S_W'(r_cp[l] >>> qslp_pkg::Q30_FB);
            end
        end
    end

    // ------------------------------------------------------------------
    // Ratios sin((1-t)w)/sin(w) and sin(tw)/sin(w).
    // ------------------------------------------------------------------
    logic signed [qslp_pkg::K_W-1:0] ka;
    logic signed [qslp_pkg::K_W-1:0] kb;

    qslp_div u_div_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_s[2]),
        .i_den  (r_s[0]),
        .o_quot (ka)
    );

    qslp_div u_div_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_s[1]),
        .i_den  (r_s[0]),
        .o_quot (kb)
    );

    // Degenerate: zero sine magnitude, or a sine of w that is not positive.
    always_comb begin
        n_flg[0] = 1'b0;
        for (int k = 1; k < DEPTH; k++) begin
            n_flg[k] = r_flg[k-1];
        end
        n_flg[A0] = (r_srt[A0-1] == '0);
        n_flg[D0] = r_flg[SA] || (r_s[0] <= 0);
    end

    // ------------------------------------------------------------------
    // Blend, round half up, saturate.
    // ------------------------------------------------------------------
    qslp_pkg::t_quat        qa_b;
    qslp_pkg::t_quat        qb_b;
    qslp_pkg::t_quat        qa_e;
    logic signed [BP_W-1:0] r_bpa [4];
    logic signed [BP_W-1:0] r_bpb [4];
    logic signed [BS_W-1:0] bsum  [4];
    logic signed [BS_W-1:0] bsh   [4];
    logic signed [15:0]     res   [4];
    qslp_pkg::t_rsp         r_rsp;
    qslp_pkg::t_rsp         n_rsp;

    assign qa_b = qslp_pkg::a_vec(r_ctx[DL]);
    assign qb_b = qslp_pkg::b_vec(r_ctx[DL]);
    assign qa_e = qslp_pkg::a_vec(r_ctx[BS]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_bpa[i] <= BP_W'($signed(qa_b[i])) * BP_W'(ka);
                r_bpb[i] <= BP_W'($signed(qb_b[i])) * BP_W'(kb);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            bsum[i] = BS_W'(r_bpa[i]) + BS_W'(r_bpb[i])
                    + BS_W'(qslp_pkg::ONE_Q30 >>> 1);
            bsh[i]  = bsum[i] >>> qslp_pkg::Q30_FB;
            if (r_flg[BS]) begin
                res[i] = $signed(qa_e[i]);
            end else if (bsh[i] > BS_W'(qslp_pkg::Q_MAX)) begin
                res[i] = qslp_pkg::Q_MAX;
            end else if (bsh[i] < BS_W'(qslp_pkg::Q_MIN)) begin
                res[i] = qslp_pkg::Q_MIN;
            end else begin
                res[i] = 16'(bsh[i]);
            end
        end
        n_rsp.r_x        = res[0];
        n_rsp.r_y        = res[1];
        n_rsp.r_z        = res[2];
        n_rsp.r_w        = res[3];
        n_rsp.degenerate = r_flg[BS];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rsp <= n_rsp;
        end
    end

    // ------------------------------------------------------------------
    // Result register with skid: park a result that arrives while the
    // result register is held, drain the skid first.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (en && r_vld[ES]) begin
                if (!r_out_vld || i_out_ready) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (r_out_vld && i_out_ready) begin
                if (r_skid_vld) begin
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_vld[ES]) begin
            if (!r_out_vld || i_out_ready) begin
                r_out <= r_rsp;
            end else begin
                r_skid <= r_rsp;
            end
        end else if (r_out_vld && i_out_ready && r_skid_vld) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_rsp       = r_out;

endmodule

`default_nettype wire

// File: hdl/qslp_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "quaternion_slerp_top_assert.svh"

module qslp_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input qslp_pkg::t_rsp o_rsp
);

    // Hold a stalled result.
    `QSLP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_rsp), "stalled result changed")

    // Request side only stalls while a result is being held.
    `QSLP_ASSERT_NOW(a_stall_cause, !o_in_ready, o_out_valid, "request stall without a held result")

    // A taken result frees the skid, so requests resume next cycle.
    `QSLP_ASSERT_NEXT(a_stall_release, !o_in_ready && i_out_ready, o_in_ready && o_out_valid, "skid not drained")

    // Drop a result only after it was taken.
    `QSLP_ASSERT_NOW(a_out_drop, $fell(o_out_valid), $past(i_out_ready), "result dropped untaken")

endmodule

bind quaternion_slerp_top qslp_chk u_qslp_chk (.*);

`default_nettype wire
